/* design/gbr_pkg.sv */
// gbr_pkg: shared constants, payload structs and weight table of the 7x7 blur
// depends on nothing; used by every module of the blur block
package gbr_pkg;

  localparam int MAX_WIDTH   = 1024;
  localparam int MAX_HEIGHT  = 4096;
  localparam int KR          = 3;
  localparam int KS          = 2 * KR + 1;
  localparam int RING_ROWS   = 8;
  localparam int SLOT_W      = $clog2(RING_ROWS);
  localparam int COL_W       = $clog2(MAX_WIDTH);
  localparam int WID_W       = 11;
  localparam int HGT_W       = 13;
  localparam int ROW_W       = 13;
  localparam int CFG_W       = 13;
  localparam int CFG_IDX_W   = 1;
  localparam int LEAD_W      = $clog2(3 * MAX_WIDTH + 4);
  localparam int FIFO_DEPTH  = 8;
  localparam int FIFO_PTR_W  = $clog2(FIFO_DEPTH);
  localparam int FIFO_CNT_W  = $clog2(FIFO_DEPTH + 1);
  localparam int WT_W        = 14;
  localparam int ROWSUM_W    = 24;
  localparam int SUM_W       = 25;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_FRAME_WIDTH  = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_FRAME_HEIGHT = 1'b1;

  // q0.16 weights indexed by |dy|, |dx|
  localparam logic [WT_W-1:0] WEIGHT_Q16 [4][4] = '{
    '{14'd10436, 14'd6330, 14'd1412, 14'd116},
    '{14'd6330,  14'd3839, 14'd857,  14'd70},
    '{14'd1412,  14'd857,  14'd191,  14'd16},
    '{14'd116,   14'd70,   14'd16,   14'd1}
  };

  typedef struct packed {
    logic [7:0] red_in;
    logic [7:0] green_in;
    logic [7:0] blue_in;
    logic [7:0] alpha_in;
    logic       drain;
  } pix_in_t;

  typedef struct packed {
    logic [7:0] red_out;
    logic [7:0] green_out;
    logic [7:0] blue_out;
    logic [7:0] alpha_out;
    logic       frame_done;
  } pix_out_t;

  // one column of the window, entry i is row offset i - KR
  typedef logic [KS-1:0][31:0] column_t;

  // one push into the line store and window, with its output tag
  typedef struct packed {
    logic              valid;
    logic              wr;
    logic [COL_W-1:0]  addr;
    logic [SLOT_W-1:0] slot;
    logic [31:0]       pixel;
    logic              emit;
    logic              done;
    logic [KS-1:0]     rowok;
    logic [KS-1:0]     colok;
  } push_t;

  typedef struct packed {
    logic emit_c;
    logic emit_d;
  } mac_status_t;

  function automatic logic [WT_W-1:0] weight(input logic [2:0] i, input logic [2:0] j);
    logic [1:0] ai;
    logic [1:0] aj;
    ai = (i >= 3'(KR)) ? 2'(i - 3'(KR)) : 2'(3'(KR) - i);
    aj = (j >= 3'(KR)) ? 2'(j - 3'(KR)) : 2'(3'(KR) - j);
    return WEIGHT_Q16[ai][aj];
  endfunction

endpackage

/* design/gbr_line_mem.sv */
// gbr_line_mem: column-wide line store, one word holds one column of the row ring
// read-modify-write with one-deep forwarding; depends on gbr_pkg
module gbr_line_mem (
  input  logic               clk,
  input  logic               rst,
  input  gbr_pkg::push_t     req,
  output gbr_pkg::push_t     cur,
  output gbr_pkg::column_t   col
);

  typedef logic [gbr_pkg::RING_ROWS-1:0][31:0] word_t;

  word_t mem [gbr_pkg::MAX_WIDTH];
  word_t rdata;
  word_t last_word;
  word_t merged;
  logic  hit;

  // read stage, write-back and forwarding flag
  always_ff @(posedge clk) begin
    rdata     <= mem[req.addr];
    last_word <= merged;
    if (cur.valid && cur.wr) begin
      mem[cur.addr] <= merged;
    end
    if (rst) begin
      cur.valid <= 1'b0;
      cur.emit  <= 1'b0;
      hit       <= 1'b0;
    end else begin
      cur.valid <= req.valid;
      cur.emit  <= req.emit;
      hit       <= req.valid && cur.valid && cur.wr && (cur.addr == req.addr);
    end
    cur.wr    <= req.wr;
    cur.addr  <= req.addr;
    cur.slot  <= req.slot;
    cur.pixel <= req.pixel;
    cur.done  <= req.done;
    cur.rowok <= req.rowok;
    cur.colok <= req.colok;
  end

  // merge the new pixel into its row slot
  always_comb begin
    merged = hit ? last_word : rdata;
    if (cur.wr) begin
      merged[cur.slot] = cur.pixel;
    end
  end

  // column of the last KS rows, oldest first
  always_comb begin
    for (int i = 0; i < gbr_pkg::KS; i++) begin
      col[i] = merged[gbr_pkg::SLOT_W'(cur.slot +
                      gbr_pkg::SLOT_W'(gbr_pkg::RING_ROWS - (gbr_pkg::KS - 1) + i))];
    end
  end

endmodule

/* design/gbr_window_mac.sv */
// gbr_window_mac: 7x7 window shift registers and the two-stage weighted sum
// depends on gbr_pkg
module gbr_window_mac (
  input  logic                  clk,
  input  logic                  rst,
  input  gbr_pkg::push_t        cur,
  input  gbr_pkg::column_t      col,
  output logic                  res_write,
  output gbr_pkg::pix_out_t     res,
  output gbr_pkg::mac_status_t  status
);

  gbr_pkg::column_t win [gbr_pkg::KS];
  logic                          c_emit;
  logic                          c_done;
  logic [gbr_pkg::KS-1:0]        c_rowok;
  logic [gbr_pkg::KS-1:0]        c_colok;
  logic [gbr_pkg::ROWSUM_W-1:0]  rs      [4][gbr_pkg::KS];
  logic [gbr_pkg::ROWSUM_W-1:0]  rs_d    [4][gbr_pkg::KS];
  logic                          d_emit;
  logic                          d_done;
  logic [gbr_pkg::SUM_W-1:0]     total   [4];
  logic [7:0]                    chan    [4];

  // window shift on every push, newest column at the top index
  always_ff @(posedge clk) begin
    if (cur.valid) begin
      for (int j = 0; j < gbr_pkg::KS - 1; j++) begin
        win[j] <= win[j+1];
      end
      win[gbr_pkg::KS-1] <= col;
    end
    if (rst) begin
      c_emit <= 1'b0;
      d_emit <= 1'b0;
    end else begin
      c_emit <= cur.valid && cur.emit;
      d_emit <= c_emit;
    end
    c_done  <= cur.done;
    c_rowok <= cur.rowok;
    c_colok <= cur.colok;
    d_done  <= c_done;
    rs_d    <= rs;
  end

  // row sums with edge masking
  always_comb begin
    for (int ch = 0; ch < 4; ch++) begin
      for (int i = 0; i < gbr_pkg::KS; i++) begin
        rs[ch][i] = '0;
        for (int j = 0; j < gbr_pkg::KS; j++) begin
          if (c_rowok[i] && c_colok[j]) begin
            rs[ch][i] = rs[ch][i] + gbr_pkg::ROWSUM_W'(win[j][i][8*ch +: 8] *
                        gbr_pkg::weight(3'(i), 3'(j)));
          end
        end
      end
    end
  end

  // column of row sums, truncate and clamp
  always_comb begin
    for (int ch = 0; ch < 4; ch++) begin
      total[ch] = '0;
      for (int i = 0; i < gbr_pkg::KS; i++) begin
        total[ch] = total[ch] + gbr_pkg::SUM_W'(rs_d[ch][i]);
      end
      chan[ch] = (total[ch][gbr_pkg::SUM_W-1:24] != '0) ? 8'hff : total[ch][23:16];
    end
  end

  assign res_write      = d_emit;
  assign res.red_out    = chan[0];
  assign res.green_out  = chan[1];
  assign res.blue_out   = chan[2];
  assign res.alpha_out  = chan[3];
  assign res.frame_done = d_done;
  assign status.emit_c  = c_emit;
  assign status.emit_d  = d_emit;

endmodule

/* design/gbr_out_fifo.sv */
// gbr_out_fifo: small result queue that parts the pipeline from the output stall
// depends on gbr_pkg
module gbr_out_fifo (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            wr,
  input  gbr_pkg::pix_out_t               wdata,
  output logic                            blur_valid,
  input  logic                            blur_stall,
  output gbr_pkg::pix_out_t               blur,
  output logic [gbr_pkg::FIFO_CNT_W-1:0]  count
);

  gbr_pkg::pix_out_t                 buffer [gbr_pkg::FIFO_DEPTH];
  logic [gbr_pkg::FIFO_PTR_W-1:0]    head;
  logic [gbr_pkg::FIFO_PTR_W-1:0]    tail;
  logic                              pop;

  assign blur_valid = (count != '0);
  assign pop        = blur_valid && !blur_stall;
  assign blur       = buffer[head];

  // queue pointers and storage
  always_ff @(posedge clk) begin
    if (wr) begin
      buffer[tail] <= wdata;
    end
    if (rst) begin
      head  <= '0;
      tail  <= '0;
      count <= '0;
    end else begin
      if (wr) tail <= tail + 1'b1;
      if (pop) head <= head + 1'b1;
      count <= count + gbr_pkg::FIFO_CNT_W'(wr) - gbr_pkg::FIFO_CNT_W'(pop);
    end
  end

endmodule

/* design/gaussian_blur_rgba_7x7_top.sv */
// gaussian_blur_rgba_7x7_top: raster counters, push sequencer and result credit
// depends on gbr_pkg, gbr_line_mem, gbr_window_mac, gbr_out_fifo
//
//   channel  signals                          payload
//   pixel    pixel_valid / pixel_stall        gbr_pkg::pix_in_t
//   blur     blur_valid / blur_stall          gbr_pkg::pix_out_t
//   config   cfg_write, cfg_index, cfg_data   frame_width (0), frame_height (1)
//
// one pixel per cycle while pixel_stall is low; results pass the read, window and
// sum registers and the queue; frames with fewer than 3*width+3 pixels add catch-up
// pushes at frame end, until the lead between input and output is 3*width+3;
// pixel_stall rises during catch-up and when the result queue and pipeline hold 8 results
// reset is synchronous; line store contents are undefined until written
module gaussian_blur_rgba_7x7_top (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            pixel_valid,
  output logic                            pixel_stall,
  input  gbr_pkg::pix_in_t                pixel,
  output logic                            blur_valid,
  input  logic                            blur_stall,
  output gbr_pkg::pix_out_t               blur,
  input  logic                            cfg_write,
  input  logic [gbr_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [gbr_pkg::CFG_W-1:0]       cfg_data
);

  logic [gbr_pkg::WID_W-1:0]       w_eff;
  logic [gbr_pkg::HGT_W-1:0]       h_eff;
  logic [gbr_pkg::COL_W-1:0]       in_col;
  logic [gbr_pkg::ROW_W-1:0]       in_row;
  logic [gbr_pkg::COL_W-1:0]       out_col;
  logic [gbr_pkg::ROW_W-1:0]       out_row;
  logic [gbr_pkg::LEAD_W-1:0]      lead;
  logic [gbr_pkg::LEAD_W-1:0]      lead_target;
  logic                            complete;
  logic                            aligned;
  logic                            catchup;
  logic [gbr_pkg::FIFO_CNT_W:0]    pending;
  logic [gbr_pkg::FIFO_CNT_W-1:0]  fifo_count;
  logic                            accept;
  logic                            push_go;
  logic                            real_px;
  logic                            emit_go;
  logic                            last;
  logic                            in_wrap;
  logic                            out_wrap;
  logic [gbr_pkg::WID_W-1:0]       wid_cfg;
  logic [gbr_pkg::HGT_W-1:0]       hgt_cfg;
  gbr_pkg::push_t                  req;
  gbr_pkg::push_t                  cur;
  gbr_pkg::column_t                col;
  gbr_pkg::mac_status_t            mstat;
  logic                            res_write;
  gbr_pkg::pix_out_t               res;

  // sequencing conditions
  assign lead_target = gbr_pkg::LEAD_W'({w_eff, 1'b0}) + gbr_pkg::LEAD_W'(w_eff)
                       + gbr_pkg::LEAD_W'(3);
  assign complete = (in_row >= h_eff);
  assign aligned  = (lead == lead_target);
  assign catchup  = complete && !aligned;
  assign pending  = (gbr_pkg::FIFO_CNT_W+1)'(fifo_count)
                    + (gbr_pkg::FIFO_CNT_W+1)'(cur.valid && cur.emit)
                    + (gbr_pkg::FIFO_CNT_W+1)'(mstat.emit_c)
                    + (gbr_pkg::FIFO_CNT_W+1)'(mstat.emit_d);
  assign pixel_stall = catchup || (pending >= (gbr_pkg::FIFO_CNT_W+1)'(gbr_pkg::FIFO_DEPTH));
  assign accept   = pixel_valid && !pixel_stall;
  assign real_px  = accept && !complete && !pixel.drain;
  assign push_go  = catchup || (accept && (complete || !pixel.drain));
  assign emit_go  = push_go && aligned && (out_row < h_eff);
  assign last     = emit_go && (out_row == h_eff - 1'b1)
                    && (gbr_pkg::WID_W'(out_col) == w_eff - 1'b1);
  assign in_wrap  = (gbr_pkg::WID_W'(in_col) + 1'b1 >= w_eff);
  assign out_wrap = (gbr_pkg::WID_W'(out_col) + 1'b1 >= w_eff);

  // register clamping
  always_comb begin
    wid_cfg = cfg_data[gbr_pkg::WID_W-1:0];
    if (wid_cfg == '0) begin
      wid_cfg = gbr_pkg::WID_W'(1);
    end else if (wid_cfg > gbr_pkg::WID_W'(gbr_pkg::MAX_WIDTH)) begin
      wid_cfg = gbr_pkg::WID_W'(gbr_pkg::MAX_WIDTH);
    end
    hgt_cfg = cfg_data[gbr_pkg::HGT_W-1:0];
    if (hgt_cfg == '0) begin
      hgt_cfg = gbr_pkg::HGT_W'(1);
    end else if (hgt_cfg > gbr_pkg::HGT_W'(gbr_pkg::MAX_HEIGHT)) begin
      hgt_cfg = gbr_pkg::HGT_W'(gbr_pkg::MAX_HEIGHT);
    end
  end

  // push request with edge masks of the output position
  always_comb begin
    req.valid = push_go;
    req.wr    = real_px;
    req.addr  = in_col;
    req.slot  = in_row[gbr_pkg::SLOT_W-1:0];
    req.pixel = {pixel.alpha_in, pixel.blue_in, pixel.green_in, pixel.red_in};
    req.emit  = emit_go;
    req.done  = last;
    for (int i = 0; i < gbr_pkg::KS; i++) begin
      req.rowok[i] = ((gbr_pkg::ROW_W+1)'(out_row) + (gbr_pkg::ROW_W+1)'(i)
                      >= (gbr_pkg::ROW_W+1)'(gbr_pkg::KR))
                  && ((gbr_pkg::ROW_W+1)'(out_row) + (gbr_pkg::ROW_W+1)'(i)
                      < (gbr_pkg::ROW_W+1)'(h_eff) + (gbr_pkg::ROW_W+1)'(gbr_pkg::KR));
      req.colok[i] = ((gbr_pkg::WID_W+1)'(out_col) + (gbr_pkg::WID_W+1)'(i)
                      >= (gbr_pkg::WID_W+1)'(gbr_pkg::KR))
                  && ((gbr_pkg::WID_W+1)'(out_col) + (gbr_pkg::WID_W+1)'(i)
                      < (gbr_pkg::WID_W+1)'(w_eff) + (gbr_pkg::WID_W+1)'(gbr_pkg::KR));
    end
  end

  // frame geometry and position counters
  always_ff @(posedge clk) begin
    if (rst) begin
      w_eff   <= gbr_pkg::WID_W'(1024);
      h_eff   <= gbr_pkg::HGT_W'(1024);
      in_col  <= '0;
      in_row  <= '0;
      out_col <= '0;
      out_row <= '0;
      lead    <= '0;
    end else if (cfg_write) begin
      unique case (cfg_index)
        gbr_pkg::REG_FRAME_WIDTH:  w_eff <= wid_cfg;
        gbr_pkg::REG_FRAME_HEIGHT: h_eff <= hgt_cfg;
        default: ;
      endcase
      in_col  <= '0;
      in_row  <= '0;
      out_col <= '0;
      out_row <= '0;
      lead    <= '0;
    end else if (last) begin
      in_col  <= '0;
      in_row  <= '0;
      out_col <= '0;
      out_row <= '0;
      lead    <= '0;
    end else begin
      if (push_go) begin
        if (in_wrap) begin
          in_col <= '0;
          in_row <= in_row + 1'b1;
        end else begin
          in_col <= in_col + 1'b1;
        end
      end
      if (emit_go) begin
        if (out_wrap) begin
          out_col <= '0;
          out_row <= out_row + 1'b1;
        end else begin
          out_col <= out_col + 1'b1;
        end
      end
      lead <= lead + gbr_pkg::LEAD_W'(push_go) - gbr_pkg::LEAD_W'(emit_go);
    end
  end

  gbr_line_mem u_mem (
    .clk (clk),
    .rst (rst),
    .req (req),
    .cur (cur),
    .col (col)
  );

  gbr_window_mac u_mac (
    .clk       (clk),
    .rst       (rst),
    .cur       (cur),
    .col       (col),
    .res_write (res_write),
    .res       (res),
    .status    (mstat)
  );

  gbr_out_fifo u_fifo (
    .clk        (clk),
    .rst        (rst),
    .wr         (res_write),
    .wdata      (res),
    .blur_valid (blur_valid),
    .blur_stall (blur_stall),
    .blur       (blur),
    .count      (fifo_count)
  );

endmodule
